FILE: design/res_pkg.sv
package res_pkg;

    // Port width of every sample field
    localparam int DATA_W      = 32;
    // Significant bits of a sample; higher input bits are ignored
    localparam int SAMPLE_BITS = 32;
    // Width of the squared error accumulator
    localparam int SUM_W       = 2 * DATA_W;
    // Fraction bits of the relative error (Q16.16)
    localparam int FRAC_BITS   = 16;
    // Dividend of the relative error division: error shifted up by the fraction
    localparam int DIVD_W      = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIVD_W);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified sample pair
    typedef struct packed {
        logic signed [DATA_W-1:0] orig;   // sign-extended original
        logic [DATA_W-1:0]        err;    // |restored - original|
        logic [DATA_W-1:0]        mag;    // |original|
        logic                     zero;   // original is zero: no relative error
        logic                     last;   // closes the block
    } res_item_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } res_q_status_t;

    // Back part sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_UPDATE
    } res_back_state_t;

endpackage

FILE: design/reconstruction_error_stats_top.sv
// Per-block error statistics of a lossy round trip.
// Input channel (sample_valid / sample_stall): one transaction is an original
// sample, its reconstruction and block_end, which marks the last pair of a block.
// Output channel (result_valid / result_stall): one transaction per block, sent
// after the pair marked block_end, carrying value range, peak absolute error,
// saturating squared error sum, peak relative error (Q16.16) and a sum
// saturation flag.
// The back part takes one pair at a time: a load, the bit-serial relative
// error divider (48 quotient bits, one per cycle) and an update step. A
// four-entry queue lets the front take up to four pairs ahead.
// With an empty queue, the closing pair passes the queue, the load, the
// divider and the update step before result_valid rises.
// Reset clears the queue, the sequencer, the running statistics and the output
// valid flag. While the receiver stalls, the result holds; the back part keeps
// working on pairs that do not close a block and waits at the next block end,
// and the input stalls once the queue is full.
module reconstruction_error_stats_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [res_pkg::DATA_W-1:0] original_sample,
    input  logic signed [res_pkg::DATA_W-1:0] restored_sample,
    input  logic                              block_end,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [res_pkg::DATA_W-1:0] largest_value,
    output logic signed [res_pkg::DATA_W-1:0] smallest_value,
    output logic [res_pkg::DATA_W-1:0]        value_span,
    output logic [res_pkg::DATA_W-1:0]        peak_abs_error,
    output logic [res_pkg::SUM_W-1:0]         squared_error_sum,
    output logic [res_pkg::DATA_W-1:0]        peak_rel_error,
    output logic                              error_sum_saturated
);
    import res_pkg::*;

    res_item_t     front_item, queue_item;
    res_q_status_t q_status;
    logic          push, pop;

    // Front: take and classify pairs
    res_front u_front (
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .original_sample (original_sample),
        .restored_sample (restored_sample),
        .block_end       (block_end),
        .q_status        (q_status),
        .push            (push),
        .item            (front_item)
    );

    // Queue between the two parts
    res_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (queue_item),
        .status   (q_status)
    );

    // Back: divide, accumulate, report
    res_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item                (queue_item),
        .q_status            (q_status),
        .pop                 (pop),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .largest_value       (largest_value),
        .smallest_value      (smallest_value),
        .value_span          (value_span),
        .peak_abs_error      (peak_abs_error),
        .squared_error_sum   (squared_error_sum),
        .peak_rel_error      (peak_rel_error),
        .error_sum_saturated (error_sum_saturated)
    );

endmodule

FILE: design/res_front.sv
module res_front (
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [res_pkg::DATA_W-1:0] original_sample,
    input  logic signed [res_pkg::DATA_W-1:0] restored_sample,
    input  logic                              block_end,
    input  res_pkg::res_q_status_t            q_status,
    output logic                              push,
    output res_pkg::res_item_t                item
);
    import res_pkg::*;

    localparam int EXT_SHIFT = DATA_W - SAMPLE_BITS;

    logic signed [DATA_W-1:0] orig_ext;
    logic signed [DATA_W-1:0] rest_ext;
    logic signed [DATA_W:0]   diff;

    // Keep the significant bits only, sign-extended from the top one
    assign orig_ext = (original_sample <<< EXT_SHIFT) >>> EXT_SHIFT;
    assign rest_ext = (restored_sample <<< EXT_SHIFT) >>> EXT_SHIFT;

    // Error in one extra bit so the difference cannot wrap
    assign diff = $signed({rest_ext[DATA_W-1], rest_ext}) - $signed({orig_ext[DATA_W-1], orig_ext});

    // Classify the pair for the back part
    always_comb
    begin
        item.orig = orig_ext;
        item.err  = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
        item.mag  = orig_ext[DATA_W-1] ? DATA_W'(-orig_ext) : orig_ext;
        item.zero = (orig_ext == '0);
        item.last = block_end;
    end

    // A transaction is taken whenever the queue has room
    assign sample_stall = q_status.full;
    assign push         = sample_valid && !q_status.full;

endmodule

FILE: design/res_queue.sv
module res_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  res_pkg::res_item_t     item_in,
    input  logic                   pop,
    output res_pkg::res_item_t     item_out,
    output res_pkg::res_q_status_t status
);
    import res_pkg::*;

    res_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign item_out     = slot_reg[head_reg];

    // Pointer and fill count
    always_comb
    begin
        head_next  = do_pop  ? QPTR_W'(head_reg + 1'b1) : head_reg;
        tail_next  = do_push ? QPTR_W'(tail_reg + 1'b1) : tail_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= item_in;
        end
    end

endmodule

FILE: design/res_back.sv
module res_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  res_pkg::res_item_t                item,
    input  res_pkg::res_q_status_t            q_status,
    output logic                              pop,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [res_pkg::DATA_W-1:0] largest_value,
    output logic signed [res_pkg::DATA_W-1:0] smallest_value,
    output logic [res_pkg::DATA_W-1:0]        value_span,
    output logic [res_pkg::DATA_W-1:0]        peak_abs_error,
    output logic [res_pkg::SUM_W-1:0]         squared_error_sum,
    output logic [res_pkg::DATA_W-1:0]        peak_rel_error,
    output logic                              error_sum_saturated
);
    import res_pkg::*;

    res_back_state_t state_reg, state_next;

    // Working item and divider
    res_item_t          cur_reg;
    logic [DATA_W:0]    rem_reg;
    logic [DIVD_W-1:0]  dvd_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]   sq_reg;

    // Running block statistics
    logic signed [DATA_W-1:0] max_reg, min_reg;
    logic [DATA_W-1:0]        peak_reg, rel_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     ovf_reg, first_reg;

    // Output register
    logic                     res_valid_reg;
    logic signed [DATA_W-1:0] res_max_reg, res_min_reg;
    logic [DATA_W-1:0]        res_span_reg, res_peak_reg, res_rel_reg;
    logic [SUM_W-1:0]         res_sum_reg;
    logic                     res_ovf_reg;

    logic                     out_free, div_step, commit, emit;
    logic [DATA_W:0]          trial, rem_next;
    logic                     fits;
    logic [SUM_W-1:0]         sq_next;
    logic [SUM_W:0]           sum_ext;
    logic signed [DATA_W-1:0] max_next, min_next;
    logic [DATA_W-1:0]        peak_next, rel_next, quot_sat;
    logic [SUM_W-1:0]         sum_next;
    logic                     ovf_next;

    assign out_free = !res_valid_reg || !result_stall;

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                if (!cur_reg.last || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        pop      = 1'b0;
        div_step = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            BK_IDLE:   pop      = !q_status.empty;
            BK_DIV:    div_step = 1'b1;
            BK_UPDATE: commit   = !cur_reg.last || out_free;
            default:   pop      = 1'b0;
        endcase
    end

    assign emit = commit && cur_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Restoring division step: one quotient bit a cycle
    assign trial    = {rem_reg[DATA_W-1:0], dvd_reg[DIVD_W-1]};
    assign fits     = (trial >= {1'b0, cur_reg.mag});
    assign rem_next = fits ? (trial - {1'b0, cur_reg.mag}) : trial;
    assign sq_next  = cur_reg.err * cur_reg.err;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= item;
            rem_reg <= '0;
            dvd_reg <= {item.err, {FRAC_BITS{1'b0}}};
            cnt_reg <= DIV_CNT_W'(DIVD_W - 1);
        end
        else if (div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIVD_W-2:0], fits};
            cnt_reg <= DIV_CNT_W'(cnt_reg - 1'b1);
            sq_reg  <= sq_next;
        end
    end

    // Statistics update for the finished item
    always_comb
    begin
        max_next  = (first_reg || (cur_reg.orig > max_reg)) ? cur_reg.orig : max_reg;
        min_next  = (first_reg || (cur_reg.orig < min_reg)) ? cur_reg.orig : min_reg;
        peak_next = (cur_reg.err > peak_reg) ? cur_reg.err : peak_reg;
        sum_ext   = {1'b0, sum_reg} + {1'b0, sq_reg};
        sum_next  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        ovf_next  = ovf_reg || sum_ext[SUM_W];
        quot_sat  = (|dvd_reg[DIVD_W-1:DATA_W]) ? {DATA_W{1'b1}} : dvd_reg[DATA_W-1:0];
        rel_next  = (!cur_reg.zero && (quot_sat > rel_reg)) ? quot_sat : rel_reg;
    end

    // Running state; a block end returns it to the reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            min_reg   <= '0;
            peak_reg  <= '0;
            sum_reg   <= '0;
            rel_reg   <= '0;
            ovf_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (emit)
        begin
            max_reg   <= '0;
            min_reg   <= '0;
            peak_reg  <= '0;
            sum_reg   <= '0;
            rel_reg   <= '0;
            ovf_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (commit)
        begin
            max_reg   <= max_next;
            min_reg   <= min_next;
            peak_reg  <= peak_next;
            sum_reg   <= sum_next;
            rel_reg   <= rel_next;
            ovf_reg   <= ovf_next;
            first_reg <= 1'b0;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_max_reg  <= max_next;
            res_min_reg  <= min_next;
            res_span_reg <= DATA_W'(max_next - min_next);
            res_peak_reg <= peak_next;
            res_sum_reg  <= sum_next;
            res_rel_reg  <= rel_next;
            res_ovf_reg  <= ovf_next;
        end
    end

    assign result_valid        = res_valid_reg;
    assign largest_value       = res_max_reg;
    assign smallest_value      = res_min_reg;
    assign value_span          = res_span_reg;
    assign peak_abs_error      = res_peak_reg;
    assign squared_error_sum   = res_sum_reg;
    assign peak_rel_error      = res_rel_reg;
    assign error_sum_saturated = res_ovf_reg;

endmodule

FILE: design/res_checker.sv
module res_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic signed [res_pkg::DATA_W-1:0] largest_value,
    input logic signed [res_pkg::DATA_W-1:0] smallest_value,
    input logic [res_pkg::DATA_W-1:0]        value_span,
    input logic [res_pkg::SUM_W-1:0]         squared_error_sum,
    input logic                              error_sum_saturated
);
    import res_pkg::*;

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its range
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(largest_value) && $stable(smallest_value))
        else $error("result changed while stalled");

    // Span matches the reported range
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> value_span == DATA_W'(largest_value - smallest_value))
        else $error("value span inconsistent with range");

    // Range is ordered
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> largest_value >= smallest_value)
        else $error("largest value below smallest value");

    // A saturated sum reads all ones
    a_saturation: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error_sum_saturated |-> squared_error_sum == {SUM_W{1'b1}})
        else $error("saturation flag without saturated sum");

endmodule

bind reconstruction_error_stats_top res_checker u_res_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .largest_value       (largest_value),
    .smallest_value      (smallest_value),
    .value_span          (value_span),
    .squared_error_sum   (squared_error_sum),
    .error_sum_saturated (error_sum_saturated)
);

FILE: tb/reconstruction_error_stats_top_tb.sv
`timescale 1ns / 1ps

module reconstruction_error_stats_top_tb;

    import res_pkg::*;

    // One block's statistics as carried by the result channel
    typedef struct {
        logic signed [DATA_W-1:0] largest;
        logic signed [DATA_W-1:0] smallest;
        logic [DATA_W-1:0]        span;
        logic [DATA_W-1:0]        peak_err;
        logic [SUM_W-1:0]         sq_sum;
        logic [DATA_W-1:0]        peak_rel;
        logic                     saturated;
    } block_stats_t;

    // Running block statistics and the blocks still owed by the DUT
    class error_stats_board;
        longint            run_max;
        longint            run_min;
        bit [DATA_W-1:0]   peak_err;
        bit [DATA_W-1:0]   peak_rel;
        bit [SUM_W-1:0]    sq_sum;
        bit                overflowed;
        bit                first_pending;
        block_stats_t      expected_blocks[$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
            clear_block();
        endfunction

        function void clear_block();
            run_max       = 0;
            run_min       = 0;
            peak_err      = '0;
            peak_rel      = '0;
            sq_sum        = '0;
            overflowed    = 1'b0;
            first_pending = 1'b1;
        endfunction

        // Keep the significant sample bits, sign-extended
        function longint widen(bit [DATA_W-1:0] raw);
            bit [63:0] v;
            v = {32'b0, raw} & ((64'd1 << SAMPLE_BITS) - 64'd1);
            if (v[SAMPLE_BITS-1])
                v = v - (64'd1 << SAMPLE_BITS);
            return longint'(v);
        endfunction

        // Fold one accepted pair into the block; closing pair queues a result
        function void note_pair(bit [DATA_W-1:0] orig_raw, bit [DATA_W-1:0] rest_raw,
                                bit last);
            longint       orig;
            longint       rest;
            longint       diff;
            bit [63:0]    err;
            bit [63:0]    sq;
            bit [63:0]    mag;
            bit [63:0]    quot;
            bit [64:0]    wide;
            block_stats_t res;
            orig = widen(orig_raw);
            rest = widen(rest_raw);
            diff = rest - orig;
            err  = (diff < 0) ? -diff : diff;
            sq   = err * err;

            if (first_pending)
            begin
                run_max       = orig;
                run_min       = orig;
                first_pending = 1'b0;
            end
            else
            begin
                if (orig > run_max) run_max = orig;
                if (orig < run_min) run_min = orig;
            end

            if (err > peak_err)
                peak_err = err[DATA_W-1:0];

            // saturating sum of squares
            wide = {1'b0, sq_sum} + {1'b0, sq};
            if (wide[64])
            begin
                sq_sum     = '1;
                overflowed = 1'b1;
            end
            else
                sq_sum = wide[63:0];

            // relative error skipped for a zero original
            if (orig != 0)
            begin
                mag  = (orig < 0) ? -orig : orig;
                quot = (err << FRAC_BITS) / mag;
                if (quot > 64'hFFFF_FFFF)
                    quot = 64'hFFFF_FFFF;
                if (quot > peak_rel)
                    peak_rel = quot[DATA_W-1:0];
            end

            if (last)
            begin
                res.largest   = run_max[DATA_W-1:0];
                res.smallest  = run_min[DATA_W-1:0];
                res.span      = DATA_W'(run_max - run_min);
                res.peak_err  = peak_err;
                res.sq_sum    = sq_sum;
                res.peak_rel  = peak_rel;
                res.saturated = overflowed;
                expected_blocks.push_back(res);
                clear_block();
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_block_result(block_stats_t got);
            block_stats_t want;
            if (expected_blocks.size() == 0)
            begin
                report_mismatch("result transaction with no closed block pending");
                return;
            end
            want = expected_blocks.pop_front();
            if (got.largest !== want.largest)
                report_mismatch($sformatf("largest_value %h, want %h",
                                          got.largest, want.largest));
            if (got.smallest !== want.smallest)
                report_mismatch($sformatf("smallest_value %h, want %h",
                                          got.smallest, want.smallest));
            if (got.span !== want.span)
                report_mismatch($sformatf("value_span %h, want %h", got.span, want.span));
            if (got.peak_err !== want.peak_err)
                report_mismatch($sformatf("peak_abs_error %h, want %h",
                                          got.peak_err, want.peak_err));
            if (got.sq_sum !== want.sq_sum)
                report_mismatch($sformatf("squared_error_sum %h, want %h",
                                          got.sq_sum, want.sq_sum));
            if (got.peak_rel !== want.peak_rel)
                report_mismatch($sformatf("peak_rel_error %h, want %h",
                                          got.peak_rel, want.peak_rel));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("error_sum_saturated %b, want %b",
                                          got.saturated, want.saturated));
        endtask

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    logic signed [DATA_W-1:0] original_sample = '0;
    logic signed [DATA_W-1:0] restored_sample = '0;
    logic                     block_end = 1'b0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [DATA_W-1:0] largest_value;
    logic signed [DATA_W-1:0] smallest_value;
    logic [DATA_W-1:0]        value_span;
    logic [DATA_W-1:0]        peak_abs_error;
    logic [SUM_W-1:0]         squared_error_sum;
    logic [DATA_W-1:0]        peak_rel_error;
    logic                     error_sum_saturated;

    error_stats_board sb;
    block_stats_t     seen;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               hold_request = 0;
    int               hold_left = 0;
    int               pairs_sent = 0;

    reconstruction_error_stats_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .original_sample    (original_sample),
        .restored_sample    (restored_sample),
        .block_end          (block_end),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .largest_value      (largest_value),
        .smallest_value     (smallest_value),
        .value_span         (value_span),
        .peak_abs_error     (peak_abs_error),
        .squared_error_sum  (squared_error_sum),
        .peak_rel_error     (peak_rel_error),
        .error_sum_saturated(error_sum_saturated)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen.largest   = largest_value;
            seen.smallest  = smallest_value;
            seen.span      = value_span;
            seen.peak_err  = peak_abs_error;
            seen.sq_sum    = squared_error_sum;
            seen.peak_rel  = peak_rel_error;
            seen.saturated = error_sum_saturated;
            sb.check_block_result(seen);
        end
    end

    // Offer one pair, with random idle cycles ahead of it, until accepted
    task offer_pair(input logic [DATA_W-1:0] orig, input logic [DATA_W-1:0] rest,
                    input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid    <= 1'b1;
        original_sample <= orig;
        restored_sample <= rest;
        block_end       <= last;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_pair(orig, rest, last);
        pairs_sent++;
    endtask

    function logic [DATA_W-1:0] pick_original();
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2:       return $urandom_range(131071) - 65536;
            3:
                case ($urandom_range(4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            default: return $urandom_range(33554431) - 16777216;
        endcase
    endfunction

    // Reconstruction: mostly close to the original, sometimes far off
    function logic [DATA_W-1:0] pick_restored(logic [DATA_W-1:0] orig);
        case ($urandom_range(7))
            0:       return orig;
            1, 2:    return orig + $urandom_range(511) - 256;
            3:       return orig + $urandom_range(2097151) - 1048576;
            4:       return $urandom;
            5:       return orig ^ (32'h1 << $urandom_range(31));
            default: return orig + $urandom_range(65535) - 32768;
        endcase
    endfunction

    task send_block(input int len);
        logic [DATA_W-1:0] orig;
        for (int i = 0; i < len; i++)
        begin
            orig = pick_original();
            offer_pair(orig, pick_restored(orig), i == len - 1);
        end
    endtask

    task run_phase(input int idle_pct, input int stall, input int n_pairs);
        int target;
        target        = pairs_sent + n_pairs;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        while (pairs_sent < target)
        begin
            if ($urandom_range(7) == 0)
                send_block($urandom_range(40, 13));
            else
                send_block($urandom_range(12, 1));
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pair blocks: zero original, full-scale errors, clipped ratio
        offer_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        offer_pair(32'h0000_0000, 32'h0001_0000, 1'b1);
        offer_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        offer_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        offer_pair(32'h0000_0001, 32'h7FFF_FFFF, 1'b1);
        offer_pair(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        // squared error sum saturates part way through the block
        offer_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        offer_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        offer_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        offer_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        // exact reconstruction, mixed signs, a zero original inside the block
        offer_pair(32'h0003_0000, 32'h0003_0000, 1'b0);
        offer_pair(32'hFFFD_0000, 32'hFFFD_0000, 1'b0);
        offer_pair(32'h0000_0000, 32'h0000_0100, 1'b0);
        offer_pair(32'h0001_8000, 32'h0001_7F00, 1'b1);
        // every original equal: zero span
        offer_pair(32'h1234_5678, 32'h1234_5600, 1'b0);
        offer_pair(32'h1234_5678, 32'h1234_5778, 1'b0);
        offer_pair(32'h1234_5678, 32'h1234_5678, 1'b1);
        // full span of the sample range
        offer_pair(32'h8000_0000, 32'h8000_0001, 1'b0);
        offer_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1);

        run_phase(0, 0, 200);
        run_phase(84, 0, 180);
        run_phase(0, 84, 180);
        run_phase(8, 8, 180);

        // long receiver hold-off while pairs keep coming in short blocks
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 600;
        for (int b = 0; b < 30; b++)
            send_block($urandom_range(3, 1));
        run_phase(0, 0, 40);

        sample_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("PASS reconstruction_error_stats_top");
        else
            $display("FAIL reconstruction_error_stats_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("FAIL reconstruction_error_stats_top");
        $finish;
    end

endmodule
